/* sv/igri_pkg.sv */
// Package: microcode control word, datapath codes and the control program.
`default_nettype none

package igri_pkg;

    localparam int PC_W = 5;
    localparam int KC_W = 29;

    typedef logic [PC_W-1:0] pc_t;

    typedef enum logic [3:0] {
        MUL_NONE,
        MUL_XZ,
        MUL_WY,
        MUL_YZ,
        MUL_WX,
        MUL_XX,
        MUL_YY,
        MUL_LIN_DT,
        MUL_VEL_DT
    } mul_sel_t;

    typedef enum logic [2:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_LOADN,
        ACC_ADD,
        ACC_SUB,
        ACC_SHL,
        ACC_ADDK
    } acc_op_t;

    typedef enum logic [2:0] {
        K_ZERO,
        K_GRAV_RND,
        K_GRAVZ,
        K_VEL_RND,
        K_POS_RND
    } kc_t;

    typedef enum logic [2:0] {
        ST_NONE,
        ST_LIN,
        ST_VEL,
        ST_POS,
        ST_CLEAR,
        ST_DONE
    } st_op_t;

    typedef enum logic [1:0] {
        CNT_KEEP,
        CNT_INIT,
        CNT_DEC
    } cnt_op_t;

    typedef enum logic [1:0] {
        JMP_NONE,
        JMP_CHUNK,
        JMP_AXIS
    } jmp_t;

    typedef struct packed {
        mul_sel_t mul;
        acc_op_t  acc;
        kc_t      kc;
        st_op_t   st;
        cnt_op_t  cnt;
        jmp_t     jmp;
        pc_t      target;
    } ucw_t;

    localparam pc_t PC_AXIS   = 5'd8;
    localparam pc_t PC_HORNER = 5'd13;
    localparam pc_t PC_CLEAR  = 5'd18;
    localparam pc_t PC_LAST   = 5'd19;

    localparam ucw_t UCW_NOP = '{
        mul:    MUL_NONE,
        acc:    ACC_HOLD,
        kc:     K_ZERO,
        st:     ST_NONE,
        cnt:    CNT_KEEP,
        jmp:    JMP_NONE,
        target: 5'd0
    };

    // rounding offsets; gravity z also carries 0.5 in product units (1.0 after the doubling shift)
    function automatic logic [KC_W-1:0] kc_value(kc_t kc);
        logic [KC_W-1:0] v;
        unique case (kc)
            K_GRAV_RND: v = KC_W'(32'h0000_4000);
            K_GRAVZ:    v = KC_W'(32'h0800_4000);
            K_VEL_RND:  v = KC_W'(32'h0000_0800);
            K_POS_RND:  v = KC_W'(32'h0008_0000);
            default:    v = '0;
        endcase
        return v;
    endfunction

    // product register feeds the accumulator in the next microcode step
    function automatic ucw_t ucode(pc_t pc);
        ucw_t w;
        w = UCW_NOP;
        unique case (pc)
            5'd0: begin
                w.mul = MUL_XZ;
            end
            5'd1: begin
                w.mul = MUL_WY;
                w.acc = ACC_LOAD;
                w.kc  = K_GRAV_RND;
            end
            5'd2: begin
                w.mul = MUL_YZ;
                w.acc = ACC_SUB;
            end
            5'd3: begin
                w.mul = MUL_WX;
                w.acc = ACC_LOAD;
                w.kc  = K_GRAV_RND;
                w.st  = ST_LIN;
            end
            5'd4: begin
                w.mul = MUL_XX;
                w.acc = ACC_ADD;
            end
            5'd5: begin
                w.mul = MUL_YY;
                w.acc = ACC_LOADN;
                w.kc  = K_GRAVZ;
                w.st  = ST_LIN;
            end
            5'd6: begin
                w.acc = ACC_SUB;
            end
            5'd7: begin
                w.st = ST_LIN;
            end
            5'd8: begin
                w.mul = MUL_LIN_DT;
            end
            5'd9: begin
                w.acc = ACC_LOAD;
                w.kc  = K_VEL_RND;
            end
            5'd10: begin
                w.st  = ST_VEL;
                w.cnt = CNT_INIT;
            end
            5'd11: begin
                w.mul = MUL_VEL_DT;
            end
            5'd12: begin
                w.acc = ACC_LOAD;
                w.cnt = CNT_DEC;
            end
            5'd13: begin
                w.mul = MUL_VEL_DT;
            end
            5'd14: begin
                w.acc    = ACC_SHL;
                w.cnt    = CNT_DEC;
                w.jmp    = JMP_CHUNK;
                w.target = PC_HORNER;
            end
            5'd15: begin
                w.acc = ACC_ADDK;
                w.kc  = K_POS_RND;
            end
            5'd16: begin
                w.st     = ST_POS;
                w.jmp    = JMP_AXIS;
                w.target = PC_AXIS;
            end
            5'd17: begin
                w.st = ST_DONE;
            end
            5'd18: begin
                w.st = ST_CLEAR;
            end
            default: begin
                w.st = ST_DONE;
            end
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

/* sv/imu_gravity_removal_integrator.sv */
// Top level: gravity removal and semi-implicit Euler integration, microcoded datapath.
//
//  channel | dir | handshake           | payload
//  --------+-----+---------------------+------------------------------------------
//  in      | in  | in_valid / in_stall | kind, accel_x/y/z, quat_w/x/y/z, step_time
//  out     | out | out_valid/out_stall | lin_acc_x/y/z, vel_x/y/z, pos_x/y/z
//
// Integrate request: stepped by the microcode program on the single shared 17x17 multiplier;
// velocity is multiplied in NCH = ceil(ACCUM_WIDTH/16) chunks of 16 bits.
// One request in flight; in_stall is high while it runs.
// The result register frees the input side; a finished request waits in its last
// step while out_stall holds the previous result.
// Reset clears control, velocity and position.
`default_nettype none

module imu_gravity_removal_integrator #(
    parameter int ACCUM_WIDTH = 32
) (
    input  logic                clk,
    input  logic                rst_n,

    input  logic                in_valid,
    output logic                in_stall,
    input  logic                kind,
    input  logic signed [15:0]  accel_x,
    input  logic signed [15:0]  accel_y,
    input  logic signed [15:0]  accel_z,
    input  logic signed [15:0]  quat_w,
    input  logic signed [15:0]  quat_x,
    input  logic signed [15:0]  quat_y,
    input  logic signed [15:0]  quat_z,
    input  logic [15:0]         step_time,

    output logic                out_valid,
    input  logic                out_stall,
    output logic signed [16:0]  lin_acc_x,
    output logic signed [16:0]  lin_acc_y,
    output logic signed [16:0]  lin_acc_z,
    output logic signed [31:0]  vel_x,
    output logic signed [31:0]  vel_y,
    output logic signed [31:0]  vel_z,
    output logic signed [31:0]  pos_x,
    output logic signed [31:0]  pos_y,
    output logic signed [31:0]  pos_z
);

    import igri_pkg::*;

    localparam int AW    = ACCUM_WIDTH;
    localparam int NCH   = (AW + 15) / 16;
    localparam int VX_W  = NCH * 16;
    localparam int ACC_W = VX_W + 18;
    localparam int CNT_W = $clog2(NCH);
    localparam int EXT_W = (AW > 32) ? AW : 32;

    localparam logic [1:0]       AXIS_LAST = 2'd2;
    localparam logic [CNT_W-1:0] CNT_TOP   = CNT_W'(NCH - 1);
    localparam logic [AW-1:0]    ACC_MAX   = {1'b0, {(AW-1){1'b1}}};
    localparam logic [AW-1:0]    ACC_MIN   = {1'b1, {(AW-1){1'b0}}};

    // control
    logic             run_reg,       run_next;
    pc_t              pc_reg,        pc_next;
    logic [1:0]       axis_reg,      axis_next;
    logic [CNT_W-1:0] cnt_reg,       cnt_next;
    logic             out_valid_reg, out_valid_next;

    // state
    logic signed [AW-1:0] vel_reg [3];
    logic signed [AW-1:0] vel_next [3];
    logic signed [AW-1:0] pos_reg [3];
    logic signed [AW-1:0] pos_next [3];

    // request and datapath
    logic signed [15:0]    accel_reg [3];
    logic signed [15:0]    qw_reg, qx_reg, qy_reg, qz_reg;
    logic [15:0]           dt_reg;
    logic signed [33:0]    prod_reg,  prod_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic signed [16:0]    lin_reg [3];
    logic signed [16:0]    lin_next [3];

    // result
    logic signed [16:0] out_lin_reg [3];
    logic signed [31:0] out_vel_reg [3];
    logic signed [31:0] out_pos_reg [3];
    logic signed [31:0] out_vel_next [3];
    logic signed [31:0] out_pos_next [3];
    logic               out_load;

    ucw_t                    uc;
    logic                    in_accept;
    logic signed [VX_W-1:0]  vel_ext;
    logic [15:0]             chunk;
    logic signed [16:0]      mul_a, mul_b;
    logic signed [ACC_W-1:0] prod_ext, k_ext, grav, dv_sh, dp_sh;
    logic signed [19:0]      lin_diff;
    logic signed [16:0]      lin_sat;
    logic [AW:0]             vsum, psum;
    logic [AW-1:0]           vsat, psat;
    logic signed [EXT_W-1:0] vx, px;

    assign uc        = ucode(pc_reg);
    assign in_stall  = run_reg;
    assign in_accept = in_valid && !run_reg;

    // multiplier operands
    always_comb
    begin
        vel_ext = VX_W'(vel_reg[axis_reg]);
        chunk   = vel_ext[cnt_reg*16 +: 16];
        unique case (uc.mul)
            MUL_XZ:
            begin
                mul_a = {qx_reg[15], qx_reg};
                mul_b = {qz_reg[15], qz_reg};
            end
            MUL_WY:
            begin
                mul_a = {qw_reg[15], qw_reg};
                mul_b = {qy_reg[15], qy_reg};
            end
            MUL_YZ:
            begin
                mul_a = {qy_reg[15], qy_reg};
                mul_b = {qz_reg[15], qz_reg};
            end
            MUL_WX:
            begin
                mul_a = {qw_reg[15], qw_reg};
                mul_b = {qx_reg[15], qx_reg};
            end
            MUL_XX:
            begin
                mul_a = {qx_reg[15], qx_reg};
                mul_b = {qx_reg[15], qx_reg};
            end
            MUL_YY:
            begin
                mul_a = {qy_reg[15], qy_reg};
                mul_b = {qy_reg[15], qy_reg};
            end
            MUL_LIN_DT:
            begin
                mul_a = lin_reg[axis_reg];
                mul_b = {1'b0, dt_reg};
            end
            MUL_VEL_DT:
            begin
                // top chunk carries the sign, lower chunks are unsigned
                mul_a = (cnt_reg == CNT_TOP) ? {chunk[15], chunk} : {1'b0, chunk};
                mul_b = {1'b0, dt_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod_next = mul_a * mul_b;
    end

    // accumulator
    always_comb
    begin
        prod_ext = ACC_W'(prod_reg);
        k_ext    = signed'({{(ACC_W-KC_W){1'b0}}, kc_value(uc.kc)});
        case (uc.acc)
            ACC_LOAD:  acc_next = prod_ext + k_ext;
            ACC_LOADN: acc_next = k_ext - prod_ext;
            ACC_ADD:   acc_next = acc_reg + prod_ext;
            ACC_SUB:   acc_next = acc_reg - prod_ext;
            ACC_SHL:   acc_next = (acc_reg <<< 16) + prod_ext;
            ACC_ADDK:  acc_next = acc_reg + k_ext;
            default:   acc_next = acc_reg;
        endcase
    end

    // store paths
    always_comb
    begin
        grav     = acc_reg >>> 15;
        lin_diff = {{4{accel_reg[axis_reg][15]}}, accel_reg[axis_reg]} - grav[19:0];
        if (lin_diff > 20'sd65535)
            lin_sat = 17'h0FFFF;
        else if (lin_diff < -20'sd65536)
            lin_sat = 17'h10000;
        else
            lin_sat = lin_diff[16:0];

        dv_sh = acc_reg >>> 12;
        vsum  = {vel_reg[axis_reg][AW-1], vel_reg[axis_reg]} + dv_sh[AW:0];
        if (vsum[AW] != vsum[AW-1])
            vsat = vsum[AW] ? ACC_MIN : ACC_MAX;
        else
            vsat = vsum[AW-1:0];

        dp_sh = acc_reg >>> 20;
        psum  = {pos_reg[axis_reg][AW-1], pos_reg[axis_reg]} + dp_sh[AW:0];
        if (psum[AW] != psum[AW-1])
            psat = psum[AW] ? ACC_MIN : ACC_MAX;
        else
            psat = psum[AW-1:0];
    end

    // result clamp to 32 bits
    always_comb
    begin
        vx = '0;
        px = '0;
        for (int i = 0; i < 3; i++)
        begin
            vx = EXT_W'(vel_reg[i]);
            px = EXT_W'(pos_reg[i]);
            if (vx > EXT_W'(32'sh7FFF_FFFF))
                out_vel_next[i] = 32'sh7FFF_FFFF;
            else if (vx < EXT_W'(32'sh8000_0000))
                out_vel_next[i] = 32'sh8000_0000;
            else
                out_vel_next[i] = vx[31:0];
            if (px > EXT_W'(32'sh7FFF_FFFF))
                out_pos_next[i] = 32'sh7FFF_FFFF;
            else if (px < EXT_W'(32'sh8000_0000))
                out_pos_next[i] = 32'sh8000_0000;
            else
                out_pos_next[i] = px[31:0];
        end
    end

    // sequencer
    always_comb
    begin
        run_next       = run_reg;
        pc_next        = pc_reg + PC_W'(1);
        axis_next      = axis_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_load       = 1'b0;
        lin_next       = lin_reg;
        vel_next       = vel_reg;
        pos_next       = pos_reg;

        if (run_reg)
        begin
            unique case (uc.st)
                ST_LIN:
                begin
                    lin_next[axis_reg] = lin_sat;
                    axis_next = (axis_reg == AXIS_LAST) ? 2'd0 : axis_reg + 2'd1;
                end
                ST_VEL:
                begin
                    vel_next[axis_reg] = vsat;
                end
                ST_POS:
                begin
                    pos_next[axis_reg] = psat;
                end
                ST_CLEAR:
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        lin_next[i] = '0;
                        vel_next[i] = '0;
                        pos_next[i] = '0;
                    end
                end
                ST_DONE:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_load       = 1'b1;
                        out_valid_next = 1'b1;
                        run_next       = 1'b0;
                    end
                    else
                    begin
                        pc_next = pc_reg;
                    end
                end
                default:
                begin
                end
            endcase

            unique case (uc.cnt)
                CNT_INIT: cnt_next = CNT_TOP;
                CNT_DEC:  cnt_next = cnt_reg - CNT_W'(1);
                default:  cnt_next = cnt_reg;
            endcase

            unique case (uc.jmp)
                JMP_CHUNK:
                begin
                    if (cnt_reg != '0)
                        pc_next = uc.target;
                end
                JMP_AXIS:
                begin
                    if (axis_reg != AXIS_LAST)
                    begin
                        pc_next   = uc.target;
                        axis_next = axis_reg + 2'd1;
                    end
                    else
                    begin
                        axis_next = 2'd0;
                    end
                end
                default:
                begin
                end
            endcase
        end
        else if (in_valid)
        begin
            run_next  = 1'b1;
            pc_next   = kind ? PC_CLEAR : '0;
            axis_next = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg       <= 1'b0;
            pc_reg        <= '0;
            axis_reg      <= 2'd0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                vel_reg[i] <= '0;
                pos_reg[i] <= '0;
            end
        end
        else
        begin
            run_reg       <= run_next;
            pc_reg        <= pc_next;
            axis_reg      <= axis_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            vel_reg       <= vel_next;
            pos_reg       <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            accel_reg[0] <= accel_x;
            accel_reg[1] <= accel_y;
            accel_reg[2] <= accel_z;
            qw_reg       <= quat_w;
            qx_reg       <= quat_x;
            qy_reg       <= quat_y;
            qz_reg       <= quat_z;
            dt_reg       <= step_time;
        end
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        lin_reg  <= lin_next;
        if (out_load)
        begin
            out_lin_reg <= lin_reg;
            out_vel_reg <= out_vel_next;
            out_pos_reg <= out_pos_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign lin_acc_x = out_lin_reg[0];
    assign lin_acc_y = out_lin_reg[1];
    assign lin_acc_z = out_lin_reg[2];
    assign vel_x     = out_vel_reg[0];
    assign vel_y     = out_vel_reg[1];
    assign vel_z     = out_vel_reg[2];
    assign pos_x     = out_pos_reg[0];
    assign pos_y     = out_pos_reg[1];
    assign pos_z     = out_pos_reg[2];

    a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
        run_reg |-> pc_reg <= PC_LAST)
        else $error("sequencer ran past the program");

    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> run_reg && (pc_reg == '0 || pc_reg == PC_CLEAR))
        else $error("accepted request did not start at a program entry");

    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        run_reg && uc.st == ST_CLEAR |=> vel_reg[0] == '0 && pos_reg[2] == '0)
        else $error("clear step left state nonzero");

endmodule

`default_nettype wire

/* tb/sv/tb_imu_gravity_removal_integrator.sv */
// Testbench for imu_gravity_removal_integrator: directed and random requests, scoreboard check.
`default_nettype none

module tb_imu_gravity_removal_integrator;

    localparam int    ACCUM_WIDTH = 32;
    localparam longint ACC_MAX    = (longint'(1) <<< (ACCUM_WIDTH - 1)) - 1;
    localparam longint ACC_MIN    = -ACC_MAX - 1;
    localparam longint I32_MAX    = 64'sd2147483647;
    localparam longint I32_MIN    = -64'sd2147483648;
    localparam longint GRAV_ONE   = 64'sd268435456;
    localparam longint LIN_MAX    = 64'sd65535;
    localparam longint LIN_MIN    = -64'sd65536;
    localparam int    CYCLE_LIMIT = 1000000;
    localparam int    DRAIN_WAIT  = 60;

    localparam logic KIND_INTEGRATE = 1'b0;
    localparam logic KIND_CLEAR     = 1'b1;

    typedef struct {
        logic               kind;
        logic signed [15:0] ax, ay, az;
        logic signed [15:0] qw, qx, qy, qz;
        logic [15:0]        dt;
    } imu_req_t;

    typedef struct {
        logic signed [16:0] lin [3];
        logic signed [31:0] vel [3];
        logic signed [31:0] pos [3];
    } motion_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic               in_valid = 1'b0;
    logic               in_stall;
    logic               kind = KIND_INTEGRATE;
    logic signed [15:0] accel_x = '0;
    logic signed [15:0] accel_y = '0;
    logic signed [15:0] accel_z = '0;
    logic signed [15:0] quat_w = '0;
    logic signed [15:0] quat_x = '0;
    logic signed [15:0] quat_y = '0;
    logic signed [15:0] quat_z = '0;
    logic [15:0]        step_time = '0;

    logic               out_valid;
    logic               out_stall = 1'b0;
    logic signed [16:0] lin_acc_x, lin_acc_y, lin_acc_z;
    logic signed [31:0] vel_x, vel_y, vel_z;
    logic signed [31:0] pos_x, pos_y, pos_z;

    longint  vel_acc [3] = '{0, 0, 0};
    longint  pos_acc [3] = '{0, 0, 0};
    motion_t pending_motion [$];
    int      mismatches = 0;
    int      cycle_count = 0;
    int      stall_left = 0;
    bit      gaps_on = 1'b0;
    bit      stalls_on = 1'b0;

    imu_gravity_removal_integrator #(
        .ACCUM_WIDTH(ACCUM_WIDTH)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .kind(kind),
        .accel_x(accel_x),
        .accel_y(accel_y),
        .accel_z(accel_z),
        .quat_w(quat_w),
        .quat_x(quat_x),
        .quat_y(quat_y),
        .quat_z(quat_z),
        .step_time(step_time),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .lin_acc_x(lin_acc_x),
        .lin_acc_y(lin_acc_y),
        .lin_acc_z(lin_acc_z),
        .vel_x(vel_x),
        .vel_y(vel_y),
        .vel_z(vel_z),
        .pos_x(pos_x),
        .pos_y(pos_y),
        .pos_z(pos_z)
    );

    always #6 clk = ~clk;

    function automatic longint clamp_l(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic longint sat_acc(longint a, longint b);
        return clamp_l(a + b, ACC_MIN, ACC_MAX);
    endfunction

    // gravity removal, then velocity and position update (semi-implicit Euler)
    function automatic motion_t step_motion(imu_req_t r);
        motion_t m;
        longint  w, x, y, z, dt, lin, dv, hi, lo, dp;
        longint  accel [3];
        longint  grav [3];
        for (int i = 0; i < 3; i++)
        begin
            m.lin[i] = '0;
        end
        if (r.kind == KIND_CLEAR)
        begin
            for (int i = 0; i < 3; i++)
            begin
                vel_acc[i] = 0;
                pos_acc[i] = 0;
            end
        end
        else
        begin
            accel[0] = r.ax;
            accel[1] = r.ay;
            accel[2] = r.az;
            w = r.qw;
            x = r.qx;
            y = r.qy;
            z = r.qz;
            dt = r.dt;
            grav[0] = (2 * (x * z - w * y) + 32768) >>> 16;
            grav[1] = (2 * (y * z + w * x) + 32768) >>> 16;
            grav[2] = (GRAV_ONE - 2 * (x * x + y * y) + 32768) >>> 16;
            for (int i = 0; i < 3; i++)
            begin
                lin = clamp_l(accel[i] - grav[i], LIN_MIN, LIN_MAX);
                m.lin[i] = 17'(lin);
                dv = (lin * dt + 2048) >>> 12;
                vel_acc[i] = sat_acc(vel_acc[i], dv);
                hi = vel_acc[i] >>> 20;
                lo = vel_acc[i] - hi * 1048576;
                dp = hi * dt + ((lo * dt + 524288) >>> 20);
                pos_acc[i] = sat_acc(pos_acc[i], dp);
            end
        end
        for (int i = 0; i < 3; i++)
        begin
            m.vel[i] = 32'(clamp_l(vel_acc[i], I32_MIN, I32_MAX));
            m.pos[i] = 32'(clamp_l(pos_acc[i], I32_MIN, I32_MAX));
        end
        return m;
    endfunction

    function automatic imu_req_t mk_req(logic k, int ax, int ay, int az,
                                        int qw, int qx, int qy, int qz, int dt);
        imu_req_t r;
        r.kind = k;
        r.ax = 16'(ax);
        r.ay = 16'(ay);
        r.az = 16'(az);
        r.qw = 16'(qw);
        r.qx = 16'(qx);
        r.qy = 16'(qy);
        r.qz = 16'(qz);
        r.dt = 16'(dt);
        return r;
    endfunction

    function automatic imu_req_t random_req();
        return mk_req(logic'($urandom_range(0, 1)), $urandom, $urandom, $urandom,
                      $urandom, $urandom, $urandom, $urandom, $urandom);
    endfunction

    // drive one request and wait for it to be taken
    task automatic push_req(imu_req_t r);
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        in_valid  <= 1'b1;
        kind      <= r.kind;
        accel_x   <= r.ax;
        accel_y   <= r.ay;
        accel_z   <= r.az;
        quat_w    <= r.qw;
        quat_x    <= r.qx;
        quat_y    <= r.qy;
        quat_z    <= r.qz;
        step_time <= r.dt;
        do
            @(posedge clk);
        while (in_stall);
        pending_motion.push_back(step_motion(r));
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_motion.size() != 0)
            @(posedge clk);
    endtask

    task automatic report_field(string name, int axis, logic signed [31:0] exp_v,
                                logic signed [31:0] got_v);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch %s[%0d]: expected %0d, got %0d", name, axis, exp_v, got_v);
    endtask

    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_stall  <= 1'b1;
        end
        else if (stalls_on && $urandom_range(0, 7) == 0)
        begin
            stall_left <= $urandom_range(0, 18);
            out_stall  <= 1'b1;
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        motion_t want;
        motion_t got;
        if (rst_n && out_valid && !out_stall)
        begin
            got.lin = '{lin_acc_x, lin_acc_y, lin_acc_z};
            got.vel = '{vel_x, vel_y, vel_z};
            got.pos = '{pos_x, pos_y, pos_z};
            if (pending_motion.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: lin %0d %0d %0d", got.lin[0], got.lin[1],
                             got.lin[2]);
            end
            else
            begin
                want = pending_motion.pop_front();
                for (int i = 0; i < 3; i++)
                begin
                    if (got.lin[i] !== want.lin[i])
                        report_field("lin_acc", i, want.lin[i], got.lin[i]);
                    if (got.vel[i] !== want.vel[i])
                        report_field("vel", i, want.vel[i], got.vel[i]);
                    if (got.pos[i] !== want.pos[i])
                        report_field("pos", i, want.pos[i], got.pos[i]);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_imu_gravity_removal_integrator: errors");
            $finish;
        end
    end

    task automatic test_clear_from_reset();
        push_req(mk_req(KIND_CLEAR, -32768, -32768, -32768, -32768, -32768, -32768, -32768,
                        65535));
        push_req(mk_req(KIND_CLEAR, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 0));
    endtask

    task automatic test_gravity_orientations();
        push_req(mk_req(KIND_INTEGRATE, 0, 0, 4096, 16384, 0, 0, 0, 1000));
        push_req(mk_req(KIND_INTEGRATE, 0, 0, -4096, 0, 16384, 0, 0, 2000));
        push_req(mk_req(KIND_INTEGRATE, 100, -200, 300, 11585, 11585, 0, 0, 4096));
        push_req(mk_req(KIND_INTEGRATE, -4096, 4096, 0, 11585, 0, 11585, 0, 30000));
        push_req(mk_req(KIND_INTEGRATE, 1234, -999, 4000, 8192, 8192, 8192, 8192, 777));
        push_req(mk_req(KIND_INTEGRATE, 0, 0, 0, 0, 0, 0, 16384, 65535));
    endtask

    task automatic test_field_extremes();
        push_req(mk_req(KIND_INTEGRATE, 32767, 32767, 32767, 16384, 0, 0, 0, 65535));
        push_req(mk_req(KIND_INTEGRATE, -32768, -32768, -32768, 16384, 0, 0, 0, 65535));
        push_req(mk_req(KIND_INTEGRATE, 32767, -32768, 32767, 16384, 0, 0, 0, 0));
        push_req(mk_req(KIND_INTEGRATE, 32767, 32767, 32767, 0, 32767, 32767, -32768, 65535));
        push_req(mk_req(KIND_INTEGRATE, -32768, -32768, -32768, -32768, 32767, 32767, 32767,
                        65535));
        push_req(mk_req(KIND_INTEGRATE, 0, 0, 0, -32768, -32768, -32768, -32768, 1));
        push_req(mk_req(KIND_INTEGRATE, 0, 0, 0, 32767, 32767, 32767, 32767, 32768));
        push_req(mk_req(KIND_INTEGRATE, -1, 1, -1, 0, 0, 0, 0, 65535));
    endtask

    task automatic test_clear_midrun();
        push_req(mk_req(KIND_INTEGRATE, 8000, -8000, 12000, 16384, 0, 0, 0, 50000));
        push_req(mk_req(KIND_INTEGRATE, 8000, -8000, 12000, 16384, 0, 0, 0, 50000));
        push_req(mk_req(KIND_CLEAR, 5, 6, 7, 8, 9, 10, 11, 12));
        push_req(mk_req(KIND_INTEGRATE, -3000, 3000, 0, 16384, 0, 0, 0, 40000));
    endtask

    // sender holds off until the pipeline is empty
    task automatic test_drain_pause();
        repeat (3) push_req(random_req());
        wait_drained();
        repeat (3) push_req(random_req());
    endtask

    // random flight segments: an optional clear, then a run with one dt style and, unless noisy, a steady orientation
    task automatic test_random_flights(int n_items);
        int       sent;
        int       run_len;
        int       dt_style;
        bit       quat_noise;
        imu_req_t base;
        imu_req_t r;
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(0, 2) == 0)
            begin
                r = random_req();
                r.kind = KIND_CLEAR;
                push_req(r);
                sent++;
            end
            run_len = $urandom_range(4, 40);
            dt_style = $urandom_range(0, 2);
            quat_noise = ($urandom_range(0, 3) == 0);
            base = mk_req(KIND_INTEGRATE, 0, 0, 0, $urandom_range(0, 32768) - 16384,
                          $urandom_range(0, 32768) - 16384, $urandom_range(0, 32768) - 16384,
                          $urandom_range(0, 32768) - 16384, 0);
            repeat (run_len)
            begin
                r = random_req();
                r.kind = ($urandom_range(0, 19) == 0) ? KIND_CLEAR : KIND_INTEGRATE;
                if ($urandom_range(0, 2) == 0)
                begin
                    r.ax = 16'($urandom_range(0, 16384) - 8192);
                    r.ay = 16'($urandom_range(0, 16384) - 8192);
                    r.az = 16'($urandom_range(0, 16384) - 8192);
                end
                if (!quat_noise)
                begin
                    r.qw = base.qw + 16'($urandom_range(0, 64) - 32);
                    r.qx = base.qx + 16'($urandom_range(0, 64) - 32);
                    r.qy = base.qy + 16'($urandom_range(0, 64) - 32);
                    r.qz = base.qz + 16'($urandom_range(0, 64) - 32);
                end
                if (dt_style == 1)
                    r.dt = 16'($urandom_range(0, 255));
                else if (dt_style == 2)
                    r.dt = 16'($urandom_range(65000, 65535));
                push_req(r);
                sent++;
            end
        end
    endtask

    // long full-scale push: position runs into the accumulator limit
    task automatic test_accumulator_saturation();
        imu_req_t r;
        push_req(mk_req(KIND_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0));
        repeat (1100)
        begin
            r = mk_req(KIND_INTEGRATE, $urandom_range(32700, 32767),
                       $urandom_range(32700, 32767), $urandom_range(32700, 32767),
                       0, 32767, 32767, -32768, $urandom_range(65400, 65535));
            push_req(r);
        end
        repeat (40)
        begin
            r = random_req();
            r.kind = KIND_INTEGRATE;
            r.ax = -16'sd32768;
            r.qw = 16'sd16384;
            r.qx = '0;
            r.qy = '0;
            r.qz = '0;
            push_req(r);
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_clear_from_reset();
        test_gravity_orientations();
        test_field_extremes();
        test_clear_midrun();

        gaps_on   = 1'b1;
        stalls_on = 1'b1;
        test_drain_pause();
        test_random_flights(600);

        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        test_accumulator_saturation();

        wait_drained();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (mismatches == 0)
            $display("tb_imu_gravity_removal_integrator: clean");
        else
            $display("tb_imu_gravity_removal_integrator: errors");
        $finish;
    end

endmodule

`default_nettype wire

/* files.f */
sv/igri_pkg.sv
sv/imu_gravity_removal_integrator.sv
tb/sv/tb_imu_gravity_removal_integrator.sv
